@@ hw/rtl/tbsd_pkg.sv @@
// Shared types and constants for the tape block sync deframer.
// Used by the front, queue and back modules and by the top level.
`default_nettype none
package tbsd_pkg;

	localparam int PREAMBLE_LEN = 16;

	// Index of the last preamble beat: leader bytes, two sync bytes, type.
	localparam int BURST_LAST = PREAMBLE_LEN + 2;
	localparam int BIDX_W = $clog2(BURST_LAST + 1);
	localparam logic [BIDX_W-1:0] BIDX_PRE = BIDX_W'(PREAMBLE_LEN);
	localparam logic [BIDX_W-1:0] BIDX_SYNC2 = BIDX_W'(PREAMBLE_LEN + 1);
	localparam logic [BIDX_W-1:0] BIDX_LAST = BIDX_W'(BURST_LAST);

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [7:0] BYTE_LEAD = 8'h01;
	localparam logic [7:0] BYTE_SYNC1 = 8'h3C;
	localparam logic [7:0] BYTE_SYNC2 = 8'h5A;
	localparam logic [7:0] TYPE_HDR = 8'h00;
	localparam logic [7:0] TYPE_FILE = 8'h01;
	localparam logic [7:0] TYPE_END = 8'hFF;
	localparam logic [7:0] MODE_TEXT = 8'hFF;
	localparam logic [7:0] LEADER_SAT = 8'hFF;
	localparam logic [7:0] HDR_BODY_CNT = 8'd15;
	localparam logic [7:0] END_BODY_CNT = 8'd1;
	localparam logic [7:0] MODE_POS = 8'd3;

	localparam logic [1:0] ROLE_PRE = 2'd0;
	localparam logic [1:0] ROLE_TYPE = 2'd1;
	localparam logic [1:0] ROLE_LEN = 2'd2;
	localparam logic [1:0] ROLE_BODY = 2'd3;

	localparam logic [1:0] KIND_HDR = 2'd0;
	localparam logic [1:0] KIND_FILE = 2'd1;
	localparam logic [1:0] KIND_END = 2'd2;

	localparam logic [1:0] CFG_LEADER_MIN = 2'd0;
	localparam logic [1:0] CFG_BINARY_GAP = 2'd1;
	localparam logic [1:0] CFG_TEXT_GAP = 2'd2;

	localparam logic [7:0] LEADER_MIN_RST = 8'd8;
	localparam logic [15:0] BINARY_GAP_RST = 16'd1000;
	localparam logic [15:0] TEXT_GAP_RST = 16'd2000;

	// One queued command: either a single result beat or a preamble burst.
	typedef struct packed {
		logic        burst;
		logic [7:0]  data;
		logic [1:0]  role;
		logic [1:0]  kind;
		logic        last;
		logic [15:0] gap;
		logic        status;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
	} qstat_t;

endpackage
`default_nettype wire

@@ hw/rtl/tbsd_front.sv @@
// Front end of the deframer: configuration registers, leader/sync hunt and
// block framing. Emits one command per accepted byte that causes output. Uses tbsd_pkg.
`default_nettype none
module tbsd_front import tbsd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_wdata,
	input  wire logic        accept,
	input  wire logic [7:0]  data_byte,
	input  wire logic        want_header,
	input  wire logic        stream_end,
	output cmd_t             push_cmd,
	output logic             push
);

	typedef enum logic [3:0] {
		SY_INIT  = 4'b0001,
		SY_LEAD  = 4'b0010,
		SY_GOT3C = 4'b0100,
		SY_GOT5A = 4'b1000
	} sync_t;

	typedef enum logic [2:0] {
		PH_SEARCH = 3'b001,
		PH_LEN    = 3'b010,
		PH_BODY   = 3'b100
	} phase_t;

	logic [7:0]  leader_min_q;
	logic [15:0] binary_gap_q;
	logic [15:0] text_gap_q;

	sync_t       sync_q, sync_d;
	phase_t      phase_q, phase_d;
	logic [7:0]  lead_cnt_q, lead_cnt_d;
	logic [7:0]  left_q, left_d;
	logic [1:0]  kind_q, kind_d;
	logic [7:0]  mode_q, mode_d;
	logic [7:0]  len_cnt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leader_min_q <= LEADER_MIN_RST;
			binary_gap_q <= BINARY_GAP_RST;
			text_gap_q <= TEXT_GAP_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LEADER_MIN: leader_min_q <= cfg_wdata[7:0];
				CFG_BINARY_GAP: binary_gap_q <= cfg_wdata;
				CFG_TEXT_GAP:   text_gap_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (kind_q == KIND_HDR) begin
			len_cnt = HDR_BODY_CNT;
		end else if (kind_q == KIND_END) begin
			len_cnt = END_BODY_CNT;
		end else begin
			len_cnt = data_byte - 8'd1;
		end
	end

	always_comb begin
		sync_d = sync_q;
		phase_d = phase_q;
		lead_cnt_d = lead_cnt_q;
		left_d = left_q;
		kind_d = kind_q;
		mode_d = mode_q;
		push = 1'b0;
		push_cmd = '0;
		push_cmd.data = data_byte;
		push_cmd.kind = kind_q;
		if (accept) begin
			if (stream_end) begin
				push = 1'b1;
				push_cmd.data = '0;
				push_cmd.role = ROLE_PRE;
				push_cmd.kind = (phase_q == PH_SEARCH) ? KIND_HDR : kind_q;
				push_cmd.last = 1'b1;
				push_cmd.status = 1'b1;
				sync_d = SY_INIT;
				phase_d = PH_SEARCH;
				lead_cnt_d = '0;
				left_d = '0;
			end else begin
				unique case (phase_q)
					PH_LEN: begin
						push = 1'b1;
						push_cmd.role = ROLE_LEN;
						if (len_cnt == '0) begin
							push_cmd.last = 1'b1;
							sync_d = SY_INIT;
							phase_d = PH_SEARCH;
							lead_cnt_d = '0;
							left_d = '0;
						end else begin
							left_d = len_cnt;
							phase_d = PH_BODY;
						end
					end
					PH_BODY: begin
						push = 1'b1;
						push_cmd.role = ROLE_BODY;
						if (kind_q == KIND_HDR && left_q == MODE_POS) begin
							mode_d = data_byte;
						end
						if (left_q <= 8'd1) begin
							push_cmd.last = 1'b1;
							if (kind_q == KIND_HDR) begin
								push_cmd.gap = (mode_q == MODE_TEXT) ? text_gap_q : binary_gap_q;
							end
							sync_d = SY_INIT;
							phase_d = PH_SEARCH;
							lead_cnt_d = '0;
							left_d = '0;
						end else begin
							left_d = left_q - 8'd1;
						end
					end
					PH_SEARCH: begin
						unique case (sync_q)
							SY_INIT: begin
								if (data_byte == BYTE_LEAD) begin
									lead_cnt_d = 8'd1;
									sync_d = SY_LEAD;
								end
							end
							SY_LEAD: begin
								if (data_byte == BYTE_LEAD) begin
									if (lead_cnt_q != LEADER_SAT) begin
										lead_cnt_d = lead_cnt_q + 8'd1;
									end
								end else if (data_byte == BYTE_SYNC1 &&
									lead_cnt_q >= leader_min_q) begin
									lead_cnt_d = '0;
									sync_d = SY_GOT3C;
								end else begin
									lead_cnt_d = '0;
									sync_d = SY_INIT;
								end
							end
							SY_GOT3C: begin
								if (data_byte == BYTE_LEAD) begin
									lead_cnt_d = 8'd1;
									sync_d = SY_LEAD;
								end else begin
									lead_cnt_d = '0;
									sync_d = (data_byte == BYTE_SYNC2) ? SY_GOT5A : SY_INIT;
								end
							end
							SY_GOT5A: begin
								lead_cnt_d = '0;
								sync_d = SY_INIT;
								// In header mode a 0x01 here restarts a leader run.
								if (want_header && data_byte == BYTE_LEAD) begin
									lead_cnt_d = 8'd1;
									sync_d = SY_LEAD;
								end else if ((want_header && data_byte == TYPE_HDR) ||
									(!want_header && (data_byte == TYPE_FILE ||
									data_byte == TYPE_END))) begin
									push = 1'b1;
									push_cmd.burst = 1'b1;
									push_cmd.role = ROLE_TYPE;
									if (want_header) begin
										push_cmd.kind = KIND_HDR;
									end else if (data_byte == TYPE_FILE) begin
										push_cmd.kind = KIND_FILE;
									end else begin
										push_cmd.kind = KIND_END;
									end
									kind_d = push_cmd.kind;
									phase_d = PH_LEN;
									left_d = '0;
								end
							end
							default: begin
								lead_cnt_d = '0;
								sync_d = SY_INIT;
							end
						endcase
					end
					default: begin
						sync_d = SY_INIT;
						phase_d = PH_SEARCH;
						lead_cnt_d = '0;
						left_d = '0;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q <= SY_INIT;
			phase_q <= PH_SEARCH;
			lead_cnt_q <= '0;
			left_q <= '0;
			kind_q <= KIND_HDR;
			mode_q <= '0;
		end else begin
			sync_q <= sync_d;
			phase_q <= phase_d;
			lead_cnt_q <= lead_cnt_d;
			left_q <= left_d;
			kind_q <= kind_d;
			mode_q <= mode_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_body_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_BODY |-> left_q != '0)
		else $error("body phase with no bytes left");
	a_search_idle: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_SEARCH |-> sync_q == SY_INIT && lead_cnt_q == '0)
		else $error("sync hunt active inside a block");
	a_burst_starts_block: assert property (@(posedge clk) disable iff (!arst_n)
		push && push_cmd.burst |=> phase_q == PH_LEN)
		else $error("preamble burst did not open a block");
`endif

endmodule
`default_nettype wire

@@ hw/rtl/tbsd_queue.sv @@
// Short command queue between the deframer front and back ends.
// Register array with read and write pointers. Uses tbsd_pkg.
`default_nettype none
module tbsd_queue import tbsd_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  cmd_t      push_cmd,
	input  wire logic pop,
	output cmd_t      head,
	output qstat_t    stat
);

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign stat.empty = (cnt_q == '0);
	assign stat.full = (cnt_q == QCNT_W'(QDEPTH));
	assign do_push = push && !stat.full;
	assign do_pop = pop && !stat.empty;
	assign head = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QDEPTH))
		else $error("queue count out of range");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		!stat.empty && !stat.full |-> wr_q != rd_q)
		else $error("queue pointers disagree with count");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		stat.full && !do_pop |=> stat.full)
		else $error("full queue lost an entry");
`endif

endmodule
`default_nettype wire

@@ hw/rtl/tbsd_back.sv @@
// Back end of the deframer: expands queued commands into result beats and
// holds them in the output register until taken. Uses tbsd_pkg.
`default_nettype none
module tbsd_back import tbsd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  cmd_t             head,
	input  qstat_t           stat,
	output logic             pop,
	input  wire logic        m_tready,
	output logic             m_tvalid,
	output logic [7:0]       out_byte,
	output logic [1:0]       byte_role,
	output logic [1:0]       block_kind,
	output logic             last_of_block,
	output logic [15:0]      gap_ms,
	output logic             status
);

	logic              valid_q;
	logic [BIDX_W-1:0] idx_q;
	logic              load;
	cmd_t              beat;

	assign load = !stat.empty && (!valid_q || m_tready);
	assign pop = load && (!head.burst || idx_q == BIDX_LAST);

	always_comb begin
		beat = head;
		if (head.burst) begin
			beat.last = 1'b0;
			beat.gap = '0;
			beat.status = 1'b0;
			beat.role = ROLE_PRE;
			if (idx_q < BIDX_PRE) begin
				beat.data = BYTE_LEAD;
			end else if (idx_q == BIDX_PRE) begin
				beat.data = BYTE_SYNC1;
			end else if (idx_q == BIDX_SYNC2) begin
				beat.data = BYTE_SYNC2;
			end else begin
				beat.role = ROLE_TYPE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
			if (load) begin
				idx_q <= pop ? '0 : idx_q + BIDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte <= beat.data;
			byte_role <= beat.role;
			block_kind <= beat.kind;
			last_of_block <= beat.last;
			gap_ms <= beat.gap;
			status <= beat.status;
		end
	end

	assign m_tvalid = valid_q;

`ifndef NO_ASSERTIONS
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= BIDX_LAST)
		else $error("burst index out of range");
	a_burst_held: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q != '0 |-> !stat.empty && head.burst)
		else $error("burst left the queue head early");
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && status |-> last_of_block)
		else $error("error beat not marked last");
`endif

endmodule
`default_nettype wire

@@ hw/rtl/tape_block_sync_deframer.sv @@
// Top level of the tape block sync deframer.
// Connects front, queue and back; uses tbsd_pkg.
//
// Usage: tape image bytes enter on the s_ stream, one per beat; regenerated
// block bytes leave on the m_ stream. The cfg port writes leader_min (0),
// binary_gap_ms (1) and text_gap_ms (2); write these only while the block is
// idle, which the block does not enforce. Each single result passes through
// the command queue and output register. A block type byte that completes sync
// causes a burst of PREAMBLE_LEN + 3 beats (19 by default) from the back end;
// beats pass at one per cycle while m_tready is high. The front end accepts a
// byte each cycle while the four-entry command queue has room, so input stalls
// only while a preamble burst drains or when the receiver holds m_tready low.
// A stalled receiver keeps the current beat in the output register; the queue
// then fills and s_tready falls. Asynchronous reset empties the queue and
// output register, restores the register defaults and restarts the hunt.
`default_nettype none
module tape_block_sync_deframer import tbsd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_wdata,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
	input  wire logic        s_tuser,   // [0] want_header
	input  wire logic        s_tlast,   // stream_end
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // [7:0] out_byte, [23:8] gap_ms, [24] status
	output logic [3:0]       m_tuser,   // [1:0] byte_role, [3:2] block_kind
	output logic             m_tlast    // last_of_block
);

	cmd_t        push_cmd;
	cmd_t        head;
	qstat_t      stat;
	logic        push;
	logic        pop;
	logic        accept;
	logic [7:0]  out_byte;
	logic [1:0]  byte_role;
	logic [1:0]  block_kind;
	logic [15:0] gap_ms;
	logic        status;

	assign s_tready = !stat.full;
	assign accept = s_tvalid && s_tready;

	tbsd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.accept      (accept),
		.data_byte   (s_tdata),
		.want_header (s_tuser),
		.stream_end  (s_tlast),
		.push_cmd    (push_cmd),
		.push        (push)
	);

	tbsd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.stat     (stat)
	);

	tbsd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.stat          (stat),
		.pop           (pop),
		.m_tready      (m_tready),
		.m_tvalid      (m_tvalid),
		.out_byte      (out_byte),
		.byte_role     (byte_role),
		.block_kind    (block_kind),
		.last_of_block (m_tlast),
		.gap_ms        (gap_ms),
		.status        (status)
	);

	assign m_tdata = {7'd0, status, gap_ms, out_byte};
	assign m_tuser = {block_kind, byte_role};

endmodule
`default_nettype wire

@@ bench/testbench.sv @@
// Self-checking bench for the tape block sync deframer: feeds tape bytes and
// compares every regenerated block byte with a built-in predictor.
// Depends on tbsd_pkg and tape_block_sync_deframer.
`default_nettype none
module testbench import tbsd_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] CFG_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_HOLD = 120;
	localparam int SETTLE_CYCLES = 8;

	typedef enum logic [1:0] {HUNT_IDLE, HUNT_LEADER, HUNT_GOT_3C, HUNT_GOT_5A} hunt_t;
	typedef enum logic [1:0] {FR_SEARCH, FR_LENGTH, FR_BODY} frame_t;

	typedef struct {
		logic [7:0] data;
		logic       want_hdr;
		logic       stream_end;
	} tape_byte_t;

	typedef struct {
		logic [7:0]  data;
		logic [1:0]  role;
		logic [1:0]  kind;
		logic        last;
		logic [15:0] gap;
		logic        status;
	} block_byte_t;

	class deframe_scoreboard;
		logic [7:0]  leader_min;
		logic [15:0] binary_gap;
		logic [15:0] text_gap;
		hunt_t       hunt;
		logic [7:0]  lead_cnt;
		frame_t      frame;
		logic [8:0]  remaining;
		logic [1:0]  kind;
		logic [7:0]  mode;
		block_byte_t expected_bytes[$];
		int          errors;

		function new();
			leader_min = LEADER_MIN_RST;
			binary_gap = BINARY_GAP_RST;
			text_gap = TEXT_GAP_RST;
			kind = KIND_HDR;
			mode = 8'h00;
			errors = 0;
			restart_hunt();
		endfunction

		function void restart_hunt();
			hunt = HUNT_IDLE;
			lead_cnt = 8'd0;
			frame = FR_SEARCH;
			remaining = 9'd0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [15:0] val);
			case (idx)
				CFG_LEADER_MIN: leader_min = val[7:0];
				CFG_BINARY_GAP: binary_gap = val;
				CFG_TEXT_GAP: text_gap = val;
				default: ;
			endcase
		endfunction

		function void expect_byte(logic [7:0] d, logic [1:0] role, logic [1:0] k, logic last,
				logic [15:0] gap, logic st);
			block_byte_t e;
			e.data = d;
			e.role = role;
			e.kind = k;
			e.last = last;
			e.gap = gap;
			e.status = st;
			expected_bytes.push_back(e);
		endfunction

		function int pending();
			return expected_bytes.size();
		endfunction

		// Advances the predicted deframer by one accepted tape byte.
		function void note_tape_byte(tape_byte_t t);
			logic [7:0] b;
			logic [8:0] cnt;
			logic [15:0] gap;
			logic hit;
			logic [1:0] hit_kind;
			b = t.data;
			hit = 1'b0;
			hit_kind = KIND_HDR;
			if (t.stream_end) begin
				expect_byte(8'h00, ROLE_PRE, (frame == FR_SEARCH) ? KIND_HDR : kind, 1'b1,
					16'd0, 1'b1);
				restart_hunt();
				return;
			end
			if (frame == FR_LENGTH) begin
				if (kind == KIND_HDR)
					cnt = {1'b0, HDR_BODY_CNT};
				else if (kind == KIND_END)
					cnt = {1'b0, END_BODY_CNT};
				else
					cnt = (b == 8'h00) ? 9'd255 : {1'b0, b} - 9'd1;
				if (cnt == 9'd0) begin
					expect_byte(b, ROLE_LEN, kind, 1'b1, 16'd0, 1'b0);
					restart_hunt();
				end else begin
					expect_byte(b, ROLE_LEN, kind, 1'b0, 16'd0, 1'b0);
					remaining = cnt;
					frame = FR_BODY;
				end
				return;
			end
			if (frame == FR_BODY) begin
				if (kind == KIND_HDR && remaining == {1'b0, MODE_POS})
					mode = b;
				if (remaining <= 9'd1) begin
					gap = 16'd0;
					if (kind == KIND_HDR)
						gap = (mode == MODE_TEXT) ? text_gap : binary_gap;
					expect_byte(b, ROLE_BODY, kind, 1'b1, gap, 1'b0);
					restart_hunt();
				end else begin
					expect_byte(b, ROLE_BODY, kind, 1'b0, 16'd0, 1'b0);
					remaining = remaining - 9'd1;
				end
				return;
			end
			case (hunt)
				HUNT_IDLE: begin
					if (b == BYTE_LEAD) begin
						lead_cnt = 8'd1;
						hunt = HUNT_LEADER;
					end
				end
				HUNT_LEADER: begin
					if (b == BYTE_LEAD) begin
						if (lead_cnt != LEADER_SAT)
							lead_cnt = lead_cnt + 8'd1;
					end else if (b == BYTE_SYNC1 && lead_cnt >= leader_min) begin
						lead_cnt = 8'd0;
						hunt = HUNT_GOT_3C;
					end else begin
						lead_cnt = 8'd0;
						hunt = HUNT_IDLE;
					end
				end
				HUNT_GOT_3C: begin
					if (b == BYTE_LEAD) begin
						lead_cnt = 8'd1;
						hunt = HUNT_LEADER;
					end else begin
						lead_cnt = 8'd0;
						hunt = (b == BYTE_SYNC2) ? HUNT_GOT_5A : HUNT_IDLE;
					end
				end
				default: begin
					// In header mode a 0x01 here is taken as the start of a new leader.
					if (t.want_hdr) begin
						if (b == BYTE_LEAD) begin
							lead_cnt = 8'd1;
							hunt = HUNT_LEADER;
						end else begin
							lead_cnt = 8'd0;
							if (b == TYPE_HDR) begin
								hit = 1'b1;
								hit_kind = KIND_HDR;
							end else begin
								hunt = HUNT_IDLE;
							end
						end
					end else begin
						lead_cnt = 8'd0;
						if (b == TYPE_FILE) begin
							hit = 1'b1;
							hit_kind = KIND_FILE;
						end else if (b == TYPE_END) begin
							hit = 1'b1;
							hit_kind = KIND_END;
						end else begin
							hunt = HUNT_IDLE;
						end
					end
					if (hit) begin
						kind = hit_kind;
						for (int i = 0; i < PREAMBLE_LEN; i++)
							expect_byte(BYTE_LEAD, ROLE_PRE, hit_kind, 1'b0, 16'd0, 1'b0);
						expect_byte(BYTE_SYNC1, ROLE_PRE, hit_kind, 1'b0, 16'd0, 1'b0);
						expect_byte(BYTE_SYNC2, ROLE_PRE, hit_kind, 1'b0, 16'd0, 1'b0);
						expect_byte(b, ROLE_TYPE, hit_kind, 1'b0, 16'd0, 1'b0);
						hunt = HUNT_IDLE;
						lead_cnt = 8'd0;
						frame = FR_LENGTH;
						remaining = 9'd0;
					end
				end
			endcase
		endfunction

		task report_mismatch(string what, int got, int want);
			errors++;
			if (errors <= 40)
				$display("MISMATCH at %0t: %s got 'h%0h expected 'h%0h", $time, what, got, want);
		endtask

		task check_block_byte(block_byte_t got);
			block_byte_t e;
			if (expected_bytes.size() == 0) begin
				report_mismatch("beat with nothing expected, out_byte", got.data, 0);
				return;
			end
			e = expected_bytes.pop_front();
			if (got.data !== e.data) report_mismatch("out_byte", got.data, e.data);
			if (got.role !== e.role) report_mismatch("byte_role", got.role, e.role);
			if (got.kind !== e.kind) report_mismatch("block_kind", got.kind, e.kind);
			if (got.last !== e.last) report_mismatch("last_of_block", got.last, e.last);
			if (got.gap !== e.gap) report_mismatch("gap_ms", got.gap, e.gap);
			if (got.status !== e.status) report_mismatch("status", got.status, e.status);
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] data_byte
	logic        s_tuser;   // [0] want_header
	logic        s_tlast;   // stream_end
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // [7:0] out_byte, [23:8] gap_ms, [24] status
	logic [3:0]  m_tuser;   // [1:0] byte_role, [3:2] block_kind
	logic        m_tlast;   // last_of_block

	deframe_scoreboard sb;
	tape_byte_t tape_items[$];
	bit quiet_tail = 1'b0;
	bit hold_request = 1'b0;
	int cycles = 0;

	tape_block_sync_deframer u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(posedge clk) begin
		block_byte_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.data = m_tdata[7:0];
			got.gap = m_tdata[23:8];
			got.status = m_tdata[24];
			got.role = m_tuser[1:0];
			got.kind = m_tuser[3:2];
			got.last = m_tlast;
			sb.check_block_byte(got);
		end
	end

	// Receiver: random stalls, plus one long hold-off that backs up the block.
	initial begin
		m_tready <= 1'b0;
		@(posedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 24)) @(posedge clk);
		end
	end

	function automatic void add_byte(logic [7:0] d, logic h, logic e);
		tape_byte_t t;
		t.data = d;
		t.want_hdr = h;
		t.stream_end = e;
		tape_items.push_back(t);
	endfunction

	// A well-formed block; file_len below zero picks a random length byte.
	function automatic void add_block(logic [1:0] blk, int lead_len, int file_len);
		logic [7:0] len_byte;
		logic [7:0] mode_byte;
		int body_n;
		for (int i = 0; i < lead_len; i++)
			add_byte(BYTE_LEAD, 1'($urandom_range(0, 1)), 1'b0);
		add_byte(BYTE_SYNC1, 1'($urandom_range(0, 1)), 1'b0);
		add_byte(BYTE_SYNC2, 1'($urandom_range(0, 1)), 1'b0);
		case (blk)
			KIND_HDR: begin
				add_byte(TYPE_HDR, 1'b1, 1'b0);
				case ($urandom_range(0, 2))
					0: mode_byte = 8'h00;
					1: mode_byte = MODE_TEXT;
					default: mode_byte = 8'($urandom);
				endcase
				add_byte(8'($urandom), 1'($urandom_range(0, 1)), 1'b0);
				// The mode byte sits 14 bytes after the type byte.
				for (int p = 1; p < 16; p++)
					add_byte((p == 13) ? mode_byte : 8'($urandom), 1'($urandom_range(0, 1)), 1'b0);
			end
			KIND_FILE: begin
				add_byte(TYPE_FILE, 1'b0, 1'b0);
				if (file_len >= 0)
					len_byte = 8'(file_len);
				else if ($urandom_range(0, 29) == 0)
					len_byte = 8'($urandom_range(13, 80));
				else
					len_byte = 8'($urandom_range(1, 12));
				add_byte(len_byte, 1'($urandom_range(0, 1)), 1'b0);
				body_n = (len_byte == 8'h00) ? 255 : int'(len_byte) - 1;
				for (int i = 0; i < body_n; i++)
					add_byte(8'($urandom), 1'($urandom_range(0, 1)), 1'b0);
			end
			default: begin
				add_byte(TYPE_END, 1'b0, 1'b0);
				add_byte(8'($urandom), 1'($urandom_range(0, 1)), 1'b0);
				add_byte(8'($urandom), 1'($urandom_range(0, 1)), 1'b0);
			end
		endcase
	endfunction

	function automatic int leader_for(int lm);
		return ((lm == 0) ? 1 : lm) + int'($urandom_range(0, 3));
	endfunction

	function automatic void add_random_chunk(int lm);
		int r;
		int first;
		int cut;
		r = $urandom_range(0, 19);
		if (r <= 11) begin
			add_block(2'($urandom_range(0, 2)), leader_for(lm), -1);
		end else if (r <= 13 || (r == 14 && lm <= 1)) begin
			repeat ($urandom_range(1, 6))
				add_byte(8'($urandom), 1'($urandom_range(0, 1)), 1'b0);
		end else if (r == 14) begin
			// Leader too short for sync.
			repeat ($urandom_range(1, lm - 1))
				add_byte(BYTE_LEAD, 1'b1, 1'b0);
			add_byte(BYTE_SYNC1, 1'b1, 1'b0);
			add_byte(BYTE_SYNC2, 1'b1, 1'b0);
			add_byte(TYPE_HDR, 1'b1, 1'b0);
		end else if (r == 15) begin
			repeat (leader_for(lm))
				add_byte(BYTE_LEAD, 1'b0, 1'b0);
			add_byte(BYTE_SYNC1, 1'b0, 1'b0);
			add_byte(BYTE_SYNC2, 1'b0, 1'b0);
			add_byte(8'($urandom), 1'($urandom_range(0, 1)), 1'b0);
		end else if (r <= 18) begin
			// Block cut short by the stream running dry.
			first = tape_items.size();
			add_block(2'($urandom_range(0, 2)), leader_for(lm), -1);
			cut = $urandom_range(first, tape_items.size() - 1);
			while (tape_items.size() > cut)
				void'(tape_items.pop_back());
			add_byte(8'($urandom), 1'($urandom_range(0, 1)), 1'b1);
		end else begin
			add_byte(8'($urandom), 1'($urandom_range(0, 1)), 1'b1);
		end
	endfunction

	task automatic program_regs(int lm, int bg, int tg, bit poke_unused);
		cfg_we <= 1'b1;
		cfg_index <= CFG_LEADER_MIN;
		cfg_wdata <= 16'(lm);
		@(posedge clk);
		sb.write_reg(CFG_LEADER_MIN, 16'(lm));
		cfg_index <= CFG_BINARY_GAP;
		cfg_wdata <= 16'(bg);
		@(posedge clk);
		sb.write_reg(CFG_BINARY_GAP, 16'(bg));
		cfg_index <= CFG_TEXT_GAP;
		cfg_wdata <= 16'(tg);
		@(posedge clk);
		sb.write_reg(CFG_TEXT_GAP, 16'(tg));
		if (poke_unused) begin
			cfg_index <= CFG_UNUSED;
			cfg_wdata <= 16'($urandom);
			@(posedge clk);
			sb.write_reg(CFG_UNUSED, 16'hFFFF);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic send_all();
		tape_byte_t t;
		int beat_no;
		bit gaps_on;
		beat_no = 0;
		gaps_on = 1'b1;
		while (tape_items.size() != 0) begin
			t = tape_items.pop_front();
			s_tvalid <= 1'b1;
			s_tdata <= t.data;
			s_tuser <= t.want_hdr;
			s_tlast <= t.stream_end;
			@(posedge clk);
			while (!s_tready) @(posedge clk);
			sb.note_tape_byte(t);
			if (beat_no % 32 == 0)
				gaps_on = ($urandom_range(0, 2) != 0);
			beat_no++;
			if (!quiet_tail && gaps_on && $urandom_range(0, 4) == 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end
		end
		s_tvalid <= 1'b0;
	endtask

	task automatic drain();
		while (sb.pending() != 0) @(posedge clk);
		// Bytes that cause no result may still be in flight.
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_phase(int lm, int bg, int tg, int budget, bit poke_unused);
		int base;
		program_regs(lm, bg, tg, poke_unused);
		base = tape_items.size();
		while (tape_items.size() < base + budget)
			add_random_chunk(lm);
		send_all();
		drain();
	endtask

	initial begin
		sb = new();
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_LEADER_MIN;
		cfg_wdata <= 16'd0;
		s_tvalid <= 1'b0;
		s_tdata <= 8'd0;
		s_tuser <= 1'b0;
		s_tlast <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: idle stream end, shortest file, end block, bad type byte,
		// header mode taking 0x01 as a new leader, and a header cut short.
		add_byte(8'hA5, 1'b0, 1'b1);
		add_byte(BYTE_LEAD, 1'b0, 1'b0);
		add_byte(BYTE_SYNC1, 1'b0, 1'b0);
		add_byte(BYTE_SYNC2, 1'b0, 1'b0);
		add_byte(TYPE_FILE, 1'b0, 1'b0);
		add_byte(8'h01, 1'b0, 1'b0);
		add_byte(BYTE_LEAD, 1'b1, 1'b0);
		add_byte(BYTE_SYNC1, 1'b0, 1'b0);
		add_byte(BYTE_SYNC2, 1'b1, 1'b0);
		add_byte(TYPE_END, 1'b0, 1'b0);
		add_byte(8'h00, 1'b0, 1'b0);
		add_byte(8'h77, 1'b1, 1'b0);
		add_byte(BYTE_LEAD, 1'b0, 1'b0);
		add_byte(BYTE_SYNC1, 1'b0, 1'b0);
		add_byte(BYTE_SYNC2, 1'b0, 1'b0);
		add_byte(8'h02, 1'b0, 1'b0);
		add_byte(BYTE_LEAD, 1'b1, 1'b0);
		add_byte(BYTE_SYNC1, 1'b1, 1'b0);
		add_byte(BYTE_SYNC2, 1'b1, 1'b0);
		add_byte(TYPE_FILE, 1'b1, 1'b0);
		add_byte(BYTE_SYNC1, 1'b1, 1'b0);
		add_byte(BYTE_SYNC2, 1'b1, 1'b0);
		add_byte(TYPE_HDR, 1'b1, 1'b0);
		add_byte(8'h10, 1'b0, 1'b0);
		add_byte(8'hFF, 1'b1, 1'b0);
		add_byte(8'h5A, 1'b0, 1'b1);
		run_phase(1, BINARY_GAP_RST, TEXT_GAP_RST, 0, 1'b0);

		hold_request = 1'b1;
		run_phase(LEADER_MIN_RST, BINARY_GAP_RST, TEXT_GAP_RST, 35, 1'b0);

		// A length byte of zero stands for a 256-byte file block; the stream
		// runs dry partway through its body. The first stream end restarts the hunt.
		add_byte(8'h00, 1'b0, 1'b1);
		add_byte(BYTE_LEAD, 1'b0, 1'b0);
		add_byte(BYTE_SYNC1, 1'b0, 1'b0);
		add_byte(BYTE_SYNC2, 1'b0, 1'b0);
		add_byte(TYPE_FILE, 1'b0, 1'b0);
		add_byte(8'h00, 1'b1, 1'b0);
		repeat (4) add_byte(8'($urandom), 1'($urandom_range(0, 1)), 1'b0);
		add_byte(8'h00, 1'b0, 1'b1);
		run_phase(1, 0, 65535, 20, 1'b0);

		// Largest leader minimum, met by a leader long enough to saturate the count.
		add_byte(8'h00, 1'b0, 1'b1);
		add_block(KIND_END, 256, -1);
		run_phase(255, 65535, 0, 0, 1'b0);

		run_phase(0, $urandom_range(0, 65535), $urandom_range(0, 65535), 12, 1'b1);

		quiet_tail = 1'b1;
		run_phase($urandom_range(2, 12), $urandom_range(0, 65535), $urandom_range(0, 65535),
			12, 1'b0);

		repeat (20) @(posedge clk);
		if (sb.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
`default_nettype wire
